// ===== rtl/mtp_pkg.sv =====
// Shared types, constants and symbol helpers for the money text parser.
// No dependencies; the unit, the datapath and the controller import this package.
`default_nettype none

package mtp_pkg;

   localparam int SymbolBytes = 4;
   localparam int SymLimit = (SymbolBytes < 4) ? SymbolBytes : 4;
   localparam int CntW = $clog2(SymbolBytes + 1);

   typedef logic [CntW-1:0] cnt_type;
   typedef logic [SymbolBytes-1:0][7:0] win_type;

   localparam logic [7:0] CharDot = 8'h2E;
   localparam logic [7:0] CharComma = 8'h2C;
   localparam logic [7:0] CharOpen = 8'h28;
   localparam logic [7:0] CharClose = 8'h29;
   localparam logic [7:0] CharFive = 8'h35;
   localparam logic [31:0] SymDollar = 32'h0000_0024;
   localparam logic [31:0] SymPlus = 32'h0000_002B;
   localparam logic [31:0] SymMinus = 32'h0000_002D;
   localparam logic [31:0] SymComma = 32'h0000_002C;
   localparam logic [31:0] SymDot = 32'h0000_002E;
   localparam logic [3:0] FracDefault = 4'd2;
   localparam logic [3:0] FracMax = 4'd10;
   localparam logic [63:0] Int64Min = {1'b1, 63'd0};

   typedef enum logic [1:0] {
      MATCH_NO,
      MATCH_YES,
      MATCH_NEED
   } match_type;

   typedef enum logic [1:0] {
      STATUS_OK = 2'd0,
      STATUS_RANGE = 2'd1,
      STATUS_SYNTAX = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      CSR_FRACTION_DIGITS = 3'd0,
      CSR_DECIMAL_CHAR = 3'd1,
      CSR_GROUP_SYMBOL = 3'd2,
      CSR_CURRENCY_SYMBOL = 3'd3,
      CSR_PLUS_SYMBOL = 3'd4,
      CSR_MINUS_SYMBOL = 3'd5
   } csr_index_type;

   typedef enum logic [3:0] {
      PH_LEAD_WS,
      PH_SIGN,
      PH_POST_SIGN,
      PH_PRE_DIGIT,
      PH_DIGITS,
      PH_PAD,
      PH_TRAIL_DIGITS,
      PH_TRAIL,
      PH_ERROR
   } phase_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_CLOSE,
      ST_PAD,
      ST_EMIT
   } ctl_state_type;

   typedef struct packed {
      logic load;
      logic step;
      logic close;
      logic emit;
   } dp_cmd_type;

   typedef struct packed {
      logic busy;
      logic at_end;
      cnt_type win_count;
   } dp_stat_type;

   function automatic cnt_type sym_len(input logic [31:0] sym);
      cnt_type n;
      logic run;
      n = '0;
      run = 1'b1;
      for (int i = 0; i < SymLimit; i++) begin
         if (run && sym[8*i +: 8] != 8'd0) begin
            n = n + cnt_type'(1);
         end else begin
            run = 1'b0;
         end
      end
      return n;
   endfunction

   function automatic logic [31:0] eff_sym(input logic [31:0] sym, input logic [31:0] dflt);
      return (sym_len(sym) == '0) ? dflt : sym;
   endfunction

   function automatic match_type sym_match(input logic [31:0] sym, input win_type win,
                                           input cnt_type count, input logic at_end);
      cnt_type len;
      match_type m;
      logic done;
      len = sym_len(sym);
      m = MATCH_YES;
      done = 1'b0;
      if (len == '0) begin
         m = MATCH_NO;
         done = 1'b1;
      end
      for (int i = 0; i < SymLimit; i++) begin
         if (!done && cnt_type'(i) < len) begin
            if (cnt_type'(i) >= count) begin
               m = at_end ? MATCH_NO : MATCH_NEED;
               done = 1'b1;
            end else if (win[i] != sym[8*i +: 8]) begin
               m = MATCH_NO;
               done = 1'b1;
            end
         end
      end
      return m;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/mtp_req_if.sv =====
// Input channel: one text byte per transfer with its end marker.
// Depends on nothing.
`default_nettype none

interface mtp_req_if;
   logic valid;
   logic ready;
   logic [7:0] text_byte;
   logic end_of_text;

   modport source (output valid, output text_byte, output end_of_text, input ready);
   modport sink (input valid, input text_byte, input end_of_text, output ready);
endinterface

`default_nettype wire

// ===== rtl/mtp_rsp_if.sv =====
// Result channel: parsed amount and status, one transfer per string.
// Depends on nothing.
`default_nettype none

interface mtp_rsp_if;
   logic valid;
   logic ready;
   logic signed [63:0] amount;
   logic [1:0] status;

   modport source (output valid, output amount, output status, input ready);
   modport sink (input valid, input amount, input status, output ready);
endinterface

`default_nettype wire

// ===== rtl/mtp_csr_if.sv =====
// Register write channel: index and data per transfer.
// Depends on nothing.
`default_nettype none

interface mtp_csr_if;
   logic valid;
   logic ready;
   logic [2:0] index;
   logic [31:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/money_text_parser_unit.sv =====
// Money string parser. A byte is accepted only in the idle state and is then
// worked off in lookahead-window steps (usually one, more where a multi-byte
// symbol is resolved or a failed match drains buffered bytes) until the step
// loop closes; the next byte waits until then, as the single window-step unit
// does one step at a time. After the last byte come a close state, the padding
// steps, one per padding digit (up to ten) through the shared accumulator adder,
// the exit from the padding loop and the load of the result register. A result
// waiting in that register does not stop the next string's bytes, and register
// writes are taken every cycle out of reset. Depends on mtp_pkg and the interfaces.
`default_nettype none

module money_text_parser_unit
   import mtp_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   mtp_req_if.sink   req_chan,
   mtp_rsp_if.source rsp_chan,
   mtp_csr_if.sink   csr_chan
);

   dp_cmd_type cmd;
   dp_stat_type stat;

   assign csr_chan.ready = !reset;

   mtp_controller u_ctl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   mtp_datapath u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .csr_write   (csr_chan.valid && csr_chan.ready),
      .csr_index   (csr_chan.index),
      .csr_data    (csr_chan.data),
      .text_byte   (req_chan.text_byte),
      .end_of_text (req_chan.end_of_text),
      .amount      (rsp_chan.amount),
      .status      (rsp_chan.status)
   );

   a_window_room: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |-> (stat.win_count < cnt_type'(SymbolBytes)))
      else $error("lookahead window full at byte transfer");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.status != 2'(STATUS_OK)) |-> (rsp_chan.amount == 64'sd0))
      else $error("failed parse carries a non-zero amount");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.status <= 2'(STATUS_SYNTAX)))
      else $error("result status outside its codes");

   a_emit_drained: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (stat.win_count == '0 && !stat.busy))
      else $error("result loaded with window not drained");

endmodule

`default_nettype wire

// ===== rtl/mtp_datapath.sv =====
// Parser datapath: registers, lookahead window, phase decode and the
// accumulator adder. Depends on mtp_pkg; driven by mtp_controller commands.
`default_nettype none

module mtp_datapath
   import mtp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire dp_cmd_type  cmd,
   output dp_stat_type      stat,
   input  wire logic        csr_write,
   input  wire logic [2:0]  csr_index,
   input  wire logic [31:0] csr_data,
   input  wire logic [7:0]  text_byte,
   input  wire logic        end_of_text,
   output logic signed [63:0] amount,
   output logic [1:0]       status
);

   logic [3:0] frac_ff;
   logic [7:0] dec_ff;
   logic [31:0] grp_ff, cur_ff, plus_ff, minus_ff;

   logic [63:0] acc_ff, acc_in;
   phase_type phase_ff, phase_in;
   logic dot_ff, dot_in;
   logic [3:0] fcount_ff, fcount_in;
   logic neg_ff, neg_in;
   status_type err_ff, err_in;
   win_type win_ff, win_in;
   cnt_type count_ff, count_in;
   logic at_end_ff, at_end_in;
   logic [63:0] amount_ff, amount_in;
   status_type status_ff, status_in;

   logic [3:0] eff_frac;
   logic [7:0] eff_dec;
   logic [31:0] cur_sym, plus_sym, minus_sym, grp_sym;
   logic [7:0] c;
   logic is_ws, is_dig, frac_room;
   match_type m_cur, m_plus, m_minus, m_grp;

   logic mul_ten;
   logic [3:0] arith_d;
   logic [67:0] acc_ext, base, full;
   logic ovf;

   cnt_type take;
   logic stall, fail_hit;
   status_type fail_code;
   win_type win_sh;

   // effective register values with defaults
   always_comb begin
      eff_frac = (frac_ff > FracMax) ? FracDefault : frac_ff;
      eff_dec = (dec_ff == 8'd0) ? CharDot : dec_ff;
      cur_sym = eff_sym(cur_ff, SymDollar);
      plus_sym = eff_sym(plus_ff, SymPlus);
      minus_sym = eff_sym(minus_ff, SymMinus);
      grp_sym = eff_sym(grp_ff, (eff_dec != CharComma) ? SymComma : SymDot);
   end

   assign c = win_ff[0];
   assign is_ws = (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
   assign is_dig = (c >= 8'd48) && (c <= 8'd57);
   assign frac_room = !dot_ff || (fcount_ff < eff_frac);
   assign m_cur = sym_match(cur_sym, win_ff, count_ff, at_end_ff);
   assign m_plus = sym_match(plus_sym, win_ff, count_ff, at_end_ff);
   assign m_minus = sym_match(minus_sym, win_ff, count_ff, at_end_ff);
   assign m_grp = sym_match(grp_sym, win_ff, count_ff, at_end_ff);

   // accumulator operation: digit (x10 - d), rounding (-1) or padding (x10)
   always_comb begin
      mul_ten = 1'b1;
      arith_d = 4'd0;
      if (phase_ff == PH_DIGITS) begin
         if (is_dig && frac_room) begin
            arith_d = c[3:0];
         end else begin
            mul_ten = 1'b0;
            arith_d = 4'd1;
         end
      end
   end

   assign acc_ext = {{4{acc_ff[63]}}, acc_ff};
   assign base = mul_ten ? ((acc_ext << 3) + (acc_ext << 1)) : acc_ext;
   assign full = base - {64'd0, arith_d};
   // the accumulator never goes positive, so leaving range means below the minimum
   assign ovf = !((&full[67:63]) || (~|full[67:63]));

   always_comb begin
      take = '0;
      stall = 1'b0;
      fail_hit = 1'b0;
      fail_code = STATUS_OK;
      phase_in = phase_ff;
      acc_in = acc_ff;
      dot_in = dot_ff;
      fcount_in = fcount_ff;
      neg_in = neg_ff;
      err_in = err_ff;
      win_in = win_ff;
      count_in = count_ff;
      at_end_in = at_end_ff;
      amount_in = amount_ff;
      status_in = status_ff;

      unique case (phase_ff)
         PH_LEAD_WS, PH_POST_SIGN: begin
            if (is_ws) begin
               take = cnt_type'(1);
            end else if (m_cur == MATCH_NEED) begin
               stall = 1'b1;
            end else begin
               if (m_cur == MATCH_YES) take = sym_len(cur_sym);
               phase_in = (phase_ff == PH_LEAD_WS) ? PH_SIGN : PH_PRE_DIGIT;
            end
         end
         PH_SIGN: begin
            if (is_ws) begin
               take = cnt_type'(1);
            end else if (m_minus == MATCH_NEED) begin
               stall = 1'b1;
            end else if (m_minus == MATCH_YES) begin
               neg_in = 1'b1;
               take = sym_len(minus_sym);
               phase_in = PH_POST_SIGN;
            end else if (c == CharOpen) begin
               neg_in = 1'b1;
               take = cnt_type'(1);
               phase_in = PH_POST_SIGN;
            end else if (m_plus == MATCH_NEED) begin
               stall = 1'b1;
            end else begin
               if (m_plus == MATCH_YES) take = sym_len(plus_sym);
               phase_in = PH_POST_SIGN;
            end
         end
         PH_PRE_DIGIT: begin
            if (is_ws) take = cnt_type'(1);
            else phase_in = PH_DIGITS;
         end
         PH_DIGITS: begin
            if (is_dig && frac_room) begin
               take = cnt_type'(1);
               if (ovf) begin
                  fail_hit = 1'b1;
                  fail_code = STATUS_RANGE;
               end else begin
                  acc_in = full[63:0];
                  if (dot_ff) fcount_in = fcount_ff + 4'd1;
               end
            end else if (c == eff_dec && !dot_ff) begin
               dot_in = 1'b1;
               take = cnt_type'(1);
            end else if (m_grp == MATCH_NEED) begin
               stall = 1'b1;
            end else if (m_grp == MATCH_YES) begin
               take = sym_len(grp_sym);
            end else if (is_dig && c >= CharFive) begin
               // excess digit rounds away from zero before padding
               if (ovf) begin
                  fail_hit = 1'b1;
                  fail_code = STATUS_RANGE;
               end else begin
                  acc_in = full[63:0];
                  phase_in = PH_PAD;
               end
            end else begin
               phase_in = PH_PAD;
            end
         end
         PH_PAD: begin
            if (fcount_ff < eff_frac) begin
               if (ovf) begin
                  fail_hit = 1'b1;
                  fail_code = STATUS_RANGE;
               end else begin
                  acc_in = full[63:0];
                  fcount_in = fcount_ff + 4'd1;
               end
            end else begin
               phase_in = PH_TRAIL_DIGITS;
            end
         end
         PH_TRAIL_DIGITS: begin
            if (is_dig) take = cnt_type'(1);
            else phase_in = PH_TRAIL;
         end
         PH_TRAIL: begin
            if (is_ws || c == CharClose) begin
               take = cnt_type'(1);
            end else if (m_minus == MATCH_NEED) begin
               stall = 1'b1;
            end else if (m_minus == MATCH_YES) begin
               neg_in = 1'b1;
               take = sym_len(minus_sym);
            end else if (m_plus == MATCH_NEED) begin
               stall = 1'b1;
            end else if (m_plus == MATCH_YES) begin
               take = sym_len(plus_sym);
            end else if (m_cur == MATCH_NEED) begin
               stall = 1'b1;
            end else if (m_cur == MATCH_YES) begin
               take = sym_len(cur_sym);
            end else begin
               fail_hit = 1'b1;
               fail_code = STATUS_SYNTAX;
            end
         end
         PH_ERROR: take = count_ff;
         default: take = count_ff;
      endcase

      if (fail_hit) begin
         phase_in = PH_ERROR;
         if (err_ff == STATUS_OK) err_in = fail_code;
      end
      if (take > count_ff) take = count_ff;

      for (int i = 0; i < SymbolBytes; i++) begin
         win_sh[i] = 8'd0;
         for (int j = 0; j <= SymbolBytes; j++) begin
            if (take == cnt_type'(j) && i + j < SymbolBytes) win_sh[i] = win_ff[i + j];
         end
      end

      if (cmd.step) begin
         win_in = win_sh;
         count_in = count_ff - take;
      end else begin
         // a step that was not issued changes nothing
         phase_in = phase_ff;
         acc_in = acc_ff;
         dot_in = dot_ff;
         fcount_in = fcount_ff;
         neg_in = neg_ff;
         err_in = err_ff;
      end

      if (cmd.load) begin
         at_end_in = end_of_text;
         if (count_ff < cnt_type'(SymbolBytes)) begin
            for (int i = 0; i < SymbolBytes; i++) begin
               if (count_ff == cnt_type'(i)) win_in[i] = text_byte;
            end
            count_in = count_ff + cnt_type'(1);
         end
      end

      if (cmd.close && err_ff == STATUS_OK && phase_ff <= PH_DIGITS) begin
         phase_in = PH_PAD;
      end

      if (cmd.emit) begin
         amount_in = 64'd0;
         status_in = err_ff;
         if (err_ff == STATUS_OK) begin
            if (neg_ff) amount_in = acc_ff;
            else if (acc_ff == Int64Min) status_in = STATUS_RANGE;
            else amount_in = ~acc_ff + 64'd1;
         end
         // drop the parse state for the next string
         acc_in = 64'd0;
         phase_in = PH_LEAD_WS;
         dot_in = 1'b0;
         fcount_in = 4'd0;
         neg_in = 1'b0;
         err_in = STATUS_OK;
         count_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frac_ff <= FracDefault;
         dec_ff <= CharDot;
         grp_ff <= SymComma;
         cur_ff <= SymDollar;
         plus_ff <= SymPlus;
         minus_ff <= SymMinus;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_FRACTION_DIGITS: frac_ff <= csr_data[3:0];
            CSR_DECIMAL_CHAR: dec_ff <= csr_data[7:0];
            CSR_GROUP_SYMBOL: grp_ff <= csr_data;
            CSR_CURRENCY_SYMBOL: cur_ff <= csr_data;
            CSR_PLUS_SYMBOL: plus_ff <= csr_data;
            CSR_MINUS_SYMBOL: minus_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= 64'd0;
         phase_ff <= PH_LEAD_WS;
         dot_ff <= 1'b0;
         fcount_ff <= 4'd0;
         neg_ff <= 1'b0;
         err_ff <= STATUS_OK;
         count_ff <= '0;
         at_end_ff <= 1'b0;
      end else begin
         acc_ff <= acc_in;
         phase_ff <= phase_in;
         dot_ff <= dot_in;
         fcount_ff <= fcount_in;
         neg_ff <= neg_in;
         err_ff <= err_in;
         count_ff <= count_in;
         at_end_ff <= at_end_in;
      end
   end

   always_ff @(posedge clock) begin
      win_ff <= win_in;
      amount_ff <= amount_in;
      status_ff <= status_in;
   end

   assign stat.busy = (phase_ff == PH_PAD) || (count_ff != '0 && !stall);
   assign stat.at_end = at_end_ff;
   assign stat.win_count = count_ff;
   assign amount = amount_ff;
   assign status = status_ff;

endmodule

`default_nettype wire

// ===== rtl/mtp_controller.sv =====
// Sequencer for the parser: byte intake, window steps, end padding and
// result hand-off. Depends on mtp_pkg; commands mtp_datapath.
`default_nettype none

module mtp_controller
   import mtp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   input  wire dp_stat_type stat,
   output dp_cmd_type       cmd
);

   ctl_state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (req_valid) state_in = ST_SCAN;
         ST_SCAN: begin
            if (!stat.busy) state_in = stat.at_end ? ST_CLOSE : ST_IDLE;
         end
         ST_CLOSE: state_in = ST_PAD;
         ST_PAD: if (!stat.busy) state_in = ST_EMIT;
         ST_EMIT: if (out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            // hold off transfers while reset is applied
            req_ready = !reset;
            cmd.load = req_valid && !reset;
         end
         ST_SCAN, ST_PAD: cmd.step = stat.busy;
         ST_CLOSE: cmd.close = 1'b1;
         ST_EMIT: cmd.emit = out_free;
         default: ;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire
